// ===== rtl/wert_pkg.sv =====
// shared widths, constants and types for the worst error ratio selector
package wert_pkg;

   localparam int CODE_W     = 9;
   localparam int COUNT_IN_W = 16;
   localparam int RATIO_W    = 15;
   localparam int PCT_W      = 7;
   localparam int OUT_SLOTS  = 5;
   localparam int QBITS      = 15;
   localparam int RATIO_FULL = 25600;

   typedef struct packed {
      logic                wr;
      logic                clr;
      logic [CODE_W-1:0]   code;
      logic [RATIO_W-1:0]  ratio;
   } slot_cmd_type;

endpackage

// ===== rtl/wert_alu.sv =====
// shared subtractor used for divider steps and slot compares
module wert_alu #(
   parameter int UW = 18
) (
   input  logic [UW-1:0] a,
   input  logic [UW-1:0] b,
   output logic [UW-1:0] diff,
   output logic          borrow
);

   logic [UW:0] full;

   assign full   = {1'b0, a} - {1'b0, b};
   assign diff   = full[UW-1:0];
   assign borrow = full[UW];

endmodule

// ===== rtl/wert_slots.sv =====
// slot register file holding codes and ratios
module wert_slots #(
   parameter int NUM_SLOTS = 5,
   parameter int SIW       = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wert_pkg::slot_cmd_type        cmd,
   input  logic [SIW-1:0]                wr_idx,
   input  logic [SIW-1:0]                rd_idx,
   output logic [wert_pkg::RATIO_W-1:0]  rd_ratio,
   output logic [wert_pkg::CODE_W-1:0]   codes  [NUM_SLOTS],
   output logic [wert_pkg::RATIO_W-1:0]  ratios [NUM_SLOTS]
);

   import wert_pkg::*;

   logic [CODE_W-1:0]  code_ff  [NUM_SLOTS];
   logic [RATIO_W-1:0] ratio_ff [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            code_ff[i]  <= '0;
            ratio_ff[i] <= '0;
         end
      end else if (cmd.wr) begin
         code_ff[wr_idx]  <= cmd.code;
         ratio_ff[wr_idx] <= cmd.ratio;
      end
   end

   assign rd_ratio = ratio_ff[rd_idx];
   assign codes    = code_ff;
   assign ratios   = ratio_ff;

endmodule

// ===== rtl/worst_error_ratio_top_five_core.sv =====
// top level: keeps the slots with the worst error ratios and reports them
//
// Each item carries a character code with its error and ok counts. The error ratio,
// floor(error * 25600 / (ok + error)) in Q7.8 percent, is worked out by a restoring
// divider that produces one quotient bit per cycle through a single shared subtractor;
// the same subtractor then scans the slots one per cycle for the first smallest ratio
// below 100 percent and does the final replace compare. busy is high after start is
// taken, through the divide, scan and update states, and on an item marked last_char
// also through the output state. For a last-marked item the five slot codes
// and whole percents appear for exactly one cycle with rsp_valid high, then all slots
// clear. The receiver cannot stall: a result must be taken in the cycle it is shown.
module worst_error_ratio_top_five_core #(
   parameter int NUM_SLOTS  = 5,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [wert_pkg::CODE_W-1:0]         req_char_code,
   input  logic [wert_pkg::COUNT_IN_W-1:0]     req_error_count,
   input  logic [wert_pkg::COUNT_IN_W-1:0]     req_ok_count,
   input  logic                                req_last_char,
   output logic                                rsp_valid,
   output logic [wert_pkg::CODE_W-1:0]         rsp_slot0_char,
   output logic [wert_pkg::CODE_W-1:0]         rsp_slot1_char,
   output logic [wert_pkg::CODE_W-1:0]         rsp_slot2_char,
   output logic [wert_pkg::CODE_W-1:0]         rsp_slot3_char,
   output logic [wert_pkg::CODE_W-1:0]         rsp_slot4_char,
   output logic [wert_pkg::PCT_W-1:0]          rsp_slot0_percent,
   output logic [wert_pkg::PCT_W-1:0]          rsp_slot1_percent,
   output logic [wert_pkg::PCT_W-1:0]          rsp_slot2_percent,
   output logic [wert_pkg::PCT_W-1:0]          rsp_slot3_percent,
   output logic [wert_pkg::PCT_W-1:0]          rsp_slot4_percent
);

   import wert_pkg::*;

   localparam int CW  = (COUNT_BITS < COUNT_IN_W) ? COUNT_BITS : COUNT_IN_W;
   localparam int DW  = CW + QBITS;
   localparam int UW  = (CW + 2 > RATIO_W + 1) ? CW + 2 : RATIO_W + 1;
   localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int QCW = $clog2(QBITS);
   localparam logic [COUNT_IN_W-1:0] CMAX = COUNT_IN_W'((1 << CW) - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [QCW-1:0]     div_cnt_ff, div_cnt_in;
   logic [SIW-1:0]     slot_cnt_ff, slot_cnt_in;
   logic [SIW-1:0]     pos_ff, pos_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               last_ff, last_in;
   logic               zero_ff, zero_in;
   logic [QBITS-1:0]   num_ff, num_in;
   logic [CW:0]        rem_ff, rem_in;
   logic [CW:0]        den_ff, den_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic [RATIO_W-1:0] best_ff, best_in;

   logic [CW-1:0]      err_sat, ok_sat;
   logic [DW-1:0]      prod;
   logic [CW+1:0]      trial;
   logic [RATIO_W-1:0] ratio_eff;
   logic [UW-1:0]      alu_a, alu_b, alu_diff;
   logic               alu_borrow;

   slot_cmd_type       cmd;
   logic [SIW-1:0]     wr_idx;
   logic [RATIO_W-1:0] rd_ratio;
   logic [CODE_W-1:0]  codes  [NUM_SLOTS];
   logic [RATIO_W-1:0] ratios [NUM_SLOTS];
   logic [CODE_W-1:0]  out_code [OUT_SLOTS];
   logic [PCT_W-1:0]   out_pct  [OUT_SLOTS];

   wert_alu #(.UW(UW)) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   wert_slots #(.NUM_SLOTS(NUM_SLOTS), .SIW(SIW)) u_slots (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_idx   (wr_idx),
      .rd_idx   (slot_cnt_ff),
      .rd_ratio (rd_ratio),
      .codes    (codes),
      .ratios   (ratios)
   );

   assign err_sat   = (req_error_count > CMAX) ? CMAX[CW-1:0] : req_error_count[CW-1:0];
   assign ok_sat    = (req_ok_count > CMAX) ? CMAX[CW-1:0] : req_ok_count[CW-1:0];
   assign prod      = DW'(err_sat) * DW'(RATIO_FULL);
   assign trial     = {rem_ff, num_ff[QBITS-1]};
   assign ratio_eff = zero_ff ? '0 : quo_ff;

   always_comb begin
      state_in    = state_ff;
      div_cnt_in  = div_cnt_ff;
      slot_cnt_in = slot_cnt_ff;
      pos_in      = pos_ff;
      code_in     = code_ff;
      last_in     = last_ff;
      zero_in     = zero_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quo_in      = quo_ff;
      best_in     = best_ff;
      alu_a       = '0;
      alu_b       = '0;
      cmd         = '0;
      cmd.code    = code_ff;
      cmd.ratio   = ratio_eff;
      wr_idx      = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               code_in    = req_char_code;
               last_in    = req_last_char;
               // the quotient fits 15 bits, so the top part already sits below the divisor
               rem_in     = (CW+1)'(prod[DW-1:QBITS]);
               num_in     = prod[QBITS-1:0];
               den_in     = {1'b0, err_sat} + {1'b0, ok_sat};
               zero_in    = (den_in == '0);
               quo_in     = '0;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            alu_a  = UW'(trial);
            alu_b  = UW'(den_ff);
            num_in = {num_ff[QBITS-2:0], 1'b0};
            if (!alu_borrow) begin
               rem_in = alu_diff[CW:0];
               quo_in = {quo_ff[RATIO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CW:0];
               quo_in = {quo_ff[RATIO_W-2:0], 1'b0};
            end
            if (div_cnt_ff == QCW'(QBITS - 1)) begin
               slot_cnt_in = '0;
               pos_in      = '0;
               best_in     = RATIO_W'(RATIO_FULL);
               state_in    = ST_SCAN;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            // strict less keeps the first of equal minima
            alu_a = UW'(rd_ratio);
            alu_b = UW'(best_ff);
            if (alu_borrow) begin
               best_in = rd_ratio;
               pos_in  = slot_cnt_ff;
            end
            if (slot_cnt_ff == SIW'(NUM_SLOTS - 1)) begin
               state_in = ST_UPD;
            end else begin
               slot_cnt_in = slot_cnt_ff + 1'b1;
            end
         end
         ST_UPD: begin
            alu_a  = UW'(best_ff);
            alu_b  = UW'(ratio_eff);
            cmd.wr = alu_borrow;
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            cmd.clr  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff  <= div_cnt_in;
      slot_cnt_ff <= slot_cnt_in;
      pos_ff      <= pos_in;
      code_ff     <= code_in;
      last_ff     <= last_in;
      zero_ff     <= zero_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      best_ff     <= best_in;
   end

   // missing slots report zero
   for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_out
      if (j < NUM_SLOTS) begin : g_have
         assign out_code[j] = codes[j];
         assign out_pct[j]  = ratios[j][RATIO_W-1:RATIO_W-PCT_W];
      end else begin : g_none
         assign out_code[j] = '0;
         assign out_pct[j]  = '0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   assign rsp_slot0_char    = out_code[0];
   assign rsp_slot1_char    = out_code[1];
   assign rsp_slot2_char    = out_code[2];
   assign rsp_slot3_char    = out_code[3];
   assign rsp_slot4_char    = out_code[4];
   assign rsp_slot0_percent = out_pct[0];
   assign rsp_slot1_percent = out_pct[1];
   assign rsp_slot2_percent = out_pct[2];
   assign rsp_slot3_percent = out_pct[3];
   assign rsp_slot4_percent = out_pct[4];

endmodule
